// ===== design/dpbt_pkg.sv =====
// shared constants, types and helpers of the dirty page bitmap tracker
`timescale 1ns / 1ps

package dpbt_pkg;

  localparam int MAX_PAGES       = 65536;
  localparam int PAGES_PER_LARGE = 512;
  localparam int PAGE_SHIFT_BITS = 12;

  localparam int ENTRY_W  = 64;
  localparam int MODE_W   = 2;
  localparam int ADDR_TOP = 51;
  localparam int BIT_PRESENT = 0;
  localparam int BIT_DIRTY   = 6;
  localparam int BIT_LARGE   = 7;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int POP_W     = 7;
  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  localparam int FRAME_W = $clog2(MAX_PAGES);
  localparam int LIM_W   = FRAME_W + 1;
  localparam int TRACK_W = 17;
  localparam int CMP_W   = (LIM_W > TRACK_W) ? LIM_W : TRACK_W;
  localparam int SPAN_W  = $clog2(PAGES_PER_LARGE + 1);
  localparam int END_W   = ((LIM_W > SPAN_W) ? LIM_W : SPAN_W) + 1;
  localparam int ACC_W   = $clog2(PAGES_PER_LARGE + 1);

  localparam int NEWLY_W     = 10;
  localparam int TOTAL_W     = 17;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - NEWLY_W - TOTAL_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_PTE   = 2'd0,
    MODE_PMD   = 2'd1,
    MODE_UPPER = 2'd2,
    MODE_PHYS  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK
  } state_t;

  function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== design/dpbt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module dpbt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/dirty_page_bitmap_tracker.sv =====
// top level of the dirty page bitmap tracker: frame decode, word sequencer, counters
//
//  channel | direction | handshake              | payload
//  in      | slave     | in_tvalid / in_tready   | tdata entry_value, tuser mode
//  out     | master    | out_tvalid / out_tready | tdata newly_marked, total_marked
//  cfg     | slave     | cfg_valid / cfg_ready   | cfg_data tracked_pages
//
// for an item that touches one bitmap word, the read is issued when the item is
// accepted, and in ST_MARK the word is written back and the result is loaded.
// a large page spans up to 9 bitmap words, one read-modify-write per cycle while no held result stalls the last.
// after reset the bitmap ram is swept to zero, one word a cycle, with in_tready low;
// cfg writes are taken throughout.
// a held result stalls only the final write-back of the following item.
`timescale 1ns / 1ps

module dirty_page_bitmap_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dpbt_pkg::ENTRY_W-1:0]      in_tdata,   // [63:0] entry_value
  input  logic [dpbt_pkg::MODE_W-1:0]       in_tuser,   // [1:0] mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dpbt_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [9:0] newly_marked, [26:10] total_marked
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dpbt_pkg::TRACK_W-1:0]      cfg_data
);
  import dpbt_pkg::*;

  state_t state_r, state_nxt;

  logic [TRACK_W-1:0] tracked_r;
  logic [TOTAL_W-1:0] count_r, count_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [WADDR_W-1:0] clr_r, clr_nxt;
  logic [WADDR_W-1:0] cur_r, cur_nxt;
  logic [WADDR_W-1:0] lo_word_r, lo_word_nxt;
  logic [WADDR_W-1:0] last_word_r, last_word_nxt;
  logic [BIT_W-1:0]   lo_bit_r, lo_bit_nxt;
  logic [BIT_W-1:0]   last_bit_r, last_bit_nxt;
  logic               mark_r, mark_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [NEWLY_W-1:0] newly_r, newly_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  // decode of the incoming word
  mode_t               mode;
  logic [ENTRY_W-1:0]  e;
  logic [ENTRY_W-1:0]  base;
  logic                hit;
  logic                large_hit;
  logic [SPAN_W-1:0]   span;
  logic [LIM_W-1:0]    limit;
  logic                in_range;
  logic [LIM_W-1:0]    lo;
  logic [END_W-1:0]    end_f;
  logic [LIM_W-1:0]    hi;
  logic [LIM_W-1:0]    last;
  logic                acc_mark;
  logic [WADDR_W-1:0]  acc_word;
  logic                in_fire;

  // word update
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] lo_m, hi_m, fresh_bits;
  logic [POP_W-1:0]     pop;
  logic                 at_last;
  logic                 proceed;
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;

  assign mode = mode_t'(in_tuser);
  assign e    = in_tdata;

  always_comb begin
    hit       = 1'b0;
    large_hit = 1'b0;
    base      = ENTRY_W'(e[ADDR_TOP:PAGE_SHIFT_BITS]);
    case (mode)
      MODE_PTE: begin
        hit = e[BIT_PRESENT] && e[BIT_DIRTY];
      end
      MODE_PMD: begin
        hit       = e[BIT_PRESENT] && e[BIT_LARGE] && e[BIT_DIRTY];
        large_hit = 1'b1;
      end
      MODE_UPPER: begin
        hit = 1'b1;
      end
      default: begin
        hit  = 1'b1;
        base = e >> PAGE_SHIFT_BITS;
      end
    endcase
  end

  // a register value above the bitmap size acts as the bitmap size
  assign limit = (CMP_W'(tracked_r) > CMP_W'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
                                                         : LIM_W'(tracked_r);
  assign in_range = base < ENTRY_W'(limit);
  assign span     = large_hit ? SPAN_W'(PAGES_PER_LARGE) : SPAN_W'(1);
  assign lo       = base[LIM_W-1:0];
  assign end_f    = END_W'(lo) + END_W'(span);
  assign hi       = (end_f < END_W'(limit)) ? LIM_W'(end_f) : limit;
  assign last     = hi - LIM_W'(1);
  assign acc_mark = hit && in_range;
  assign acc_word = acc_mark ? WADDR_W'(lo >> BIT_W) : '0;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // bits of the current word inside [lo, hi) that are still clear
  assign lo_m = (cur_r == lo_word_r) ? ({WORD_BITS{1'b1}} << lo_bit_r) : {WORD_BITS{1'b1}};
  assign hi_m = (cur_r == last_word_r)
              ? ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit_r))
              : {WORD_BITS{1'b1}};
  assign fresh_bits = mark_r ? (lo_m & hi_m & ~rd_data) : '0;
  assign pop        = popcount(fresh_bits);

  assign at_last = (cur_r == last_word_r);
  assign proceed = (state_r == ST_MARK) && (!at_last || !out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    lo_word_nxt   = lo_word_r;
    last_word_nxt = last_word_r;
    lo_bit_nxt    = lo_bit_r;
    last_bit_nxt  = last_bit_r;
    mark_nxt      = mark_r;
    acc_nxt       = acc_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    newly_nxt     = newly_r;
    total_nxt     = total_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = rd_data | fresh_bits;
    ram_raddr     = cur_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + WADDR_W'(1);
        if (clr_r == WADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr = acc_word;
        if (in_fire) begin
          state_nxt     = ST_MARK;
          cur_nxt       = acc_word;
          lo_word_nxt   = acc_word;
          lo_bit_nxt    = lo[BIT_W-1:0];
          last_word_nxt = acc_mark ? WADDR_W'(last >> BIT_W) : '0;
          last_bit_nxt  = last[BIT_W-1:0];
          mark_nxt      = acc_mark;
          acc_nxt       = '0;
        end
      end
      ST_MARK: begin
        if (proceed) begin
          ram_we    = (fresh_bits != '0);
          acc_nxt   = acc_r + ACC_W'(pop);
          count_nxt = count_r + TOTAL_W'(pop);
          if (at_last) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            newly_nxt     = NEWLY_W'(acc_r + ACC_W'(pop));
            total_nxt     = count_r + TOTAL_W'(pop);
          end else begin
            cur_nxt   = cur_r + WADDR_W'(1);
            ram_raddr = cur_r + WADDR_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      tracked_r   <= '0;
      out_valid_r <= 1'b0;
      mark_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      mark_r      <= mark_nxt;
      if (cfg_valid && cfg_ready) begin
        tracked_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    lo_word_r   <= lo_word_nxt;
    last_word_r <= last_word_nxt;
    lo_bit_r    <= lo_bit_nxt;
    last_bit_r  <= last_bit_nxt;
    acc_r       <= acc_nxt;
    newly_r     <= newly_nxt;
    total_r     <= total_nxt;
  end

  dpbt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, total_r, newly_r};

endmodule

// ===== design/dpbt_checker.sv =====
// port-level checker for the dirty page bitmap tracker, bound to the top level
`timescale 1ns / 1ps

module dpbt_port_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dpbt_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import dpbt_pkg::*;

  // the bitmap sweep keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input open during bitmap sweep");

  // one word in flight: an accepted word closes the input on the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in flight");

  // no item can set more bits than one large page holds
  a_newly_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[NEWLY_W-1:0] <= NEWLY_W'(PAGES_PER_LARGE))
    else $error("newly marked count above large page size");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind dirty_page_bitmap_tracker dpbt_port_checker u_dpbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/dpbt_checker.sv =====
// checker for the dirty page bitmap tracker: mirrors the bitmap and compares each result word
`timescale 1ns / 1ps

module dpbt_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [dpbt_pkg::ENTRY_W-1:0]      in_tdata,   // [63:0] entry_value
  input  logic [dpbt_pkg::MODE_W-1:0]       in_tuser,   // [1:0] mode
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [dpbt_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [9:0] newly_marked, [26:10] total_marked
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [dpbt_pkg::TRACK_W-1:0]      cfg_data,
  output int                                fail_count,
  output int                                pending_count,
  output int                                results_checked,
  output int                                fresh_seen
);
  import dpbt_pkg::*;

  typedef struct packed {
    logic [NEWLY_W-1:0] newly_marked;
    logic [TOTAL_W-1:0] total_marked;
  } mark_report_t;

  logic [MAX_PAGES-1:0] dirty_map;
  logic [TRACK_W-1:0]   tracked_limit;
  int unsigned          marked_sum;
  mark_report_t         awaited_reports[$];
  mark_report_t         want;
  mark_report_t         got;
  int                   reports_shown;

  // sets one frame's bit if it lies below the limit, returns 1 when it was clear
  function automatic int claim_frame(input logic [52:0] frame);
    logic [52:0] lim;
    lim = 53'(tracked_limit);
    if (lim > 53'(MAX_PAGES)) lim = 53'(MAX_PAGES);
    if (frame >= lim) return 0;
    if (dirty_map[frame[FRAME_W-1:0]]) return 0;
    dirty_map[frame[FRAME_W-1:0]] = 1'b1;
    marked_sum++;
    return 1;
  endfunction

  function automatic mark_report_t predict_marking(input mode_t m, input logic [63:0] e);
    mark_report_t r;
    logic [52:0]  base;
    int           fresh;
    fresh = 0;
    base  = 53'(e[ADDR_TOP:PAGE_SHIFT_BITS]);
    case (m)
      MODE_PTE: begin
        if (e[BIT_PRESENT] && e[BIT_DIRTY]) fresh = claim_frame(base);
      end
      MODE_PMD: begin
        // only a present, dirty large page marks anything; frames past the limit drop out
        if (e[BIT_PRESENT] && e[BIT_LARGE] && e[BIT_DIRTY]) begin
          for (int i = 0; i < PAGES_PER_LARGE; i++) fresh += claim_frame(base + 53'(i));
        end
      end
      MODE_UPPER: begin
        fresh = claim_frame(base);
      end
      default: begin
        fresh = claim_frame(53'(e >> PAGE_SHIFT_BITS));
      end
    endcase
    r.newly_marked = NEWLY_W'(fresh);
    r.total_marked = TOTAL_W'(marked_sum);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dirty_map       = '0;
      marked_sum      = 0;
      tracked_limit   = '0;
      awaited_reports.delete();
      pending_count   = 0;
      fail_count      = 0;
      results_checked = 0;
      fresh_seen      = 0;
      reports_shown   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.newly_marked = out_tdata[NEWLY_W-1:0];
        got.total_marked = out_tdata[NEWLY_W +: TOTAL_W];
        results_checked++;
        fresh_seen += got.newly_marked;
        if (awaited_reports.size() == 0) begin
          fail_count++;
          if (reports_shown < 10) begin
            $display("%0t: result word with nothing outstanding: newly %0d total %0d",
                     $time, got.newly_marked, got.total_marked);
            reports_shown++;
          end
        end else begin
          want = awaited_reports.pop_front();
          if (got.newly_marked !== want.newly_marked ||
              got.total_marked !== want.total_marked) begin
            fail_count++;
            if (reports_shown < 10) begin
              $display("%0t: mismatch: newly exp %0d got %0d, total exp %0d got %0d",
                       $time, want.newly_marked, got.newly_marked,
                       want.total_marked, got.total_marked);
              reports_shown++;
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) tracked_limit = cfg_data;
      if (in_tvalid && in_tready)
        awaited_reports.push_back(predict_marking(mode_t'(in_tuser), in_tdata));
      pending_count = awaited_reports.size();
    end
  end

endmodule

// ===== bench/tb_dirty_page_bitmap_tracker.sv =====
// testbench top for the dirty page bitmap tracker: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_dirty_page_bitmap_tracker;
  import dpbt_pkg::*;

  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 300;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [ENTRY_W-1:0]     in_tdata;
  logic [MODE_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [TRACK_W-1:0]     cfg_data;

  int fail_count;
  int pending_count;
  int results_checked;
  int fresh_seen;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_seq;
  int mode_sent[4];
  int cfg_writes;
  int span;

  dirty_page_bitmap_tracker u_dut (.*);

  dpbt_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off when asked for
  initial begin
    int hold_done;
    hold_done = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_done) begin
        hold_done = hold_seq;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input mode_t m, input logic [63:0] e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= e;
    in_tuser  <= m;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mode_sent[int'(m)]++;
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tracked(input logic [TRACK_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (v == 0) span = 64;
    else if (v > MAX_PAGES) span = MAX_PAGES;
    else span = int'(v);
  endtask

  // mostly frames inside the tracked range, some around its edge, a few anywhere
  function automatic logic [63:0] make_entry(input mode_t m);
    logic [63:0] e;
    logic [51:0] frame;
    int          pick;
    int          f;
    e    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 70) begin
      frame = 52'($urandom_range(span - 1));
    end else if (pick < 88) begin
      f = span + int'($urandom_range(1100)) - 600;
      if (f < 0) f = int'($urandom_range(63));
      frame = 52'(f);
    end else begin
      frame = 52'({$urandom, $urandom});
    end
    if (m == MODE_PHYS) begin
      e = {frame, e[11:0]};
    end else begin
      e[ADDR_TOP:PAGE_SHIFT_BITS] = frame[39:0];
      if ($urandom_range(99) < 85) begin
        e[BIT_PRESENT] = 1'b1;
        e[BIT_DIRTY]   = 1'b1;
        if (m == MODE_PMD) e[BIT_LARGE] = ($urandom_range(99) < 35);
      end
    end
    return e;
  endfunction

  task automatic run_random(input int count, input int hold_at);
    mode_t m;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_seq++;
      m = mode_t'($urandom_range(3));
      send_item(m, make_entry(m));
    end
  endtask

  initial begin
    tx_idle_pct = 18;
    rx_idle_pct = 53;
    hold_seq    = 0;
    cfg_writes  = 0;
    span        = 64;
    foreach (mode_sent[i]) mode_sent[i] = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // limit still zero from reset: nothing may be marked
    send_item(MODE_UPPER, 64'h0000_0000_0000_0000);
    send_item(MODE_PHYS,  64'h0000_0000_0000_0FFF);

    // above the bitmap size, so the whole bitmap is tracked
    write_tracked(17'h1FFFF);
    send_item(MODE_PTE,   64'h0000_0000_0000_0041);
    send_item(MODE_PTE,   64'h0000_0000_0000_1001);  // present but clean
    send_item(MODE_PTE,   64'h0000_0000_0000_1040);  // dirty but not present
    send_item(MODE_PTE,   64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_PTE,   64'hFFF0_0000_0FFF_F041);  // last frame, top bits ignored
    send_item(MODE_PMD,   64'h0000_0000_0040_0041);  // pmd without the large bit
    send_item(MODE_PMD,   64'h0000_0000_0040_00C1);
    send_item(MODE_PMD,   64'h0000_0000_0040_00C1);  // same large page again
    send_item(MODE_PMD,   64'h0000_0000_0080_00C0);
    send_item(MODE_PMD,   64'h0000_0000_0080_0081);
    send_item(MODE_PMD,   64'hFFF0_0000_0FF0_0FFF);  // large page running off the end
    send_item(MODE_UPPER, 64'h0000_0000_0000_5000);
    send_item(MODE_UPPER, 64'h0000_0000_0000_5000);
    send_item(MODE_PHYS,  64'hFFFF_FFFF_FFFF_FFFF);
    send_item(MODE_PHYS,  64'h0000_0000_0003_0FFF);
    send_item(MODE_PHYS,  64'h0000_0000_0FFF_FFFF);

    // large page straddling a small limit
    write_tracked(17'd1000);
    send_item(MODE_PMD,   64'h0000_0000_0025_80C1);
    send_item(MODE_UPPER, 64'h0000_0000_003E_8000);
    write_tracked(17'd0);
    send_item(MODE_PTE,   64'h0000_0000_0000_2041);
    write_tracked(17'd1);
    send_item(MODE_PHYS,  64'h0000_0000_0000_1000);
    send_item(MODE_UPPER, 64'h0000_0000_0000_0000);

    write_tracked(17'($urandom_range(64, 16384)));
    run_random(ITEMS_PER_PHASE, -1);

    wait_drained();
    tx_idle_pct = 53;
    rx_idle_pct = 18;
    write_tracked(17'($urandom_range(16385, 65535)));
    run_random(ITEMS_PER_PHASE, -1);

    // full range, no idling, with one long hold-off on the result side to fill the block
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_tracked(17'(MAX_PAGES));
    run_random(ITEMS_PER_PHASE, 40);

    wait_drained();
    $display("summary: %0d items sent (pte %0d, pmd %0d, upper %0d, phys %0d), %0d limit writes",
             mode_sent[0] + mode_sent[1] + mode_sent[2] + mode_sent[3],
             mode_sent[0], mode_sent[1], mode_sent[2], mode_sent[3], cfg_writes);
    $display("summary: %0d result words checked, %0d frames newly marked, %0d failures",
             results_checked, fresh_seen, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
